@@ hdl/rwdp_pkg.sv @@
// ----------------------------------------------------------------------------
// rwdp_pkg
// shared constants, types and helpers of the rtt window drop probability block
// ----------------------------------------------------------------------------
`default_nettype none

package rwdp_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int RTT_BITS   = 24;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int PROB_W     = 16;
  localparam int WSIZE_W    = 7;
  localparam int PROD_W     = PROB_W + RTT_BITS;
  localparam int QUO_BITS   = PROB_W;
  localparam int STEP_W     = $clog2(QUO_BITS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RTT_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DROP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY   = 2'd3;

  localparam logic [PROB_W-1:0]   RST_RTT_SCALE   = 16'd655;
  localparam logic [PROB_W-1:0]   RST_MIN_DROP    = 16'd66;
  localparam logic [WSIZE_W-1:0]  RST_WINDOW_SIZE = 7'd30;
  localparam logic [RTT_BITS-1:0] RST_INIT_DELAY  = {RTT_BITS{1'b1}};

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [RTT_BITS-1:0] rtt;
    logic [RTT_BITS-1:0] lo;
    logic [RTT_BITS-1:0] hi;
    logic                full;
  } job_t;

  // ring index add, modulo the store depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(MAX_WINDOW)) s = s - (CNT_W+1)'(MAX_WINDOW);
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/rwdp_if.sv @@
// ----------------------------------------------------------------------------
// rwdp_if
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
`default_nettype none

interface rwdp_sample_if import rwdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RTT_BITS-1:0] rtt_sample;
  modport source(output valid, rtt_sample, input ready);
  modport sink(input valid, rtt_sample, output ready);
  modport monitor(input valid, ready, rtt_sample);
endinterface

interface rwdp_result_if import rwdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RTT_BITS-1:0] rtt_min;
  logic [RTT_BITS-1:0] rtt_max;
  logic [RTT_BITS-1:0] prop_delay;
  logic                prop_delay_lowered;
  logic                window_full;
  logic [PROB_W-1:0]   drop_prob;
  modport source(output valid, rtt_min, rtt_max, prop_delay, prop_delay_lowered,
                 window_full, drop_prob, input ready);
  modport sink(input valid, rtt_min, rtt_max, prop_delay, prop_delay_lowered,
               window_full, drop_prob, output ready);
  modport monitor(input valid, ready, rtt_min, rtt_max, prop_delay,
                  prop_delay_lowered, window_full, drop_prob);
endinterface

`default_nettype wire

@@ hdl/rwdp_front.sv @@
// ----------------------------------------------------------------------------
// rwdp_front
// stores samples in the window ring and scans it for min and max
// ----------------------------------------------------------------------------
`default_nettype none

module rwdp_front import rwdp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_wr_t cfg,
  rwdp_sample_if.sink  sample,
  output logic         push,
  output job_t         push_job,
  input  wire logic    push_ready
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state;
  logic [RTT_BITS-1:0] mem [MAX_WINDOW];
  logic [RTT_BITS-1:0] rd_data;
  logic                rd_vld;
  logic [WSIZE_W-1:0]  window_size;
  logic [CNT_W-1:0]    fill;
  logic [PTR_W-1:0]    ptr;
  logic [CNT_W-1:0]    cnt;
  logic [RTT_BITS-1:0] rtt;
  logic [RTT_BITS-1:0] lo;
  logic [RTT_BITS-1:0] hi;
  logic                full;

  logic                accept;
  logic                issue;
  logic [CNT_W-1:0]    size_eff;
  logic [CNT_W-1:0]    fill_next;
  logic [PTR_W-1:0]    ptr_next;
  logic [PTR_W-1:0]    wr_addr;
  logic [PTR_W-1:0]    rd_addr;

  assign sample.ready = (state == F_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign issue        = (state == F_SCAN) && (cnt < fill);
  assign rd_addr      = wrap_add(ptr, cnt);
  assign push         = (state == F_PUSH);
  assign push_job     = '{rtt: rtt, lo: lo, hi: hi, full: full};

  always_comb begin
    if (window_size == '0) begin
      size_eff = CNT_W'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      size_eff = CNT_W'(MAX_WINDOW);
    end else begin
      size_eff = CNT_W'(window_size);
    end
    if (fill < size_eff) begin
      wr_addr   = wrap_add(ptr, fill);
      fill_next = fill + CNT_W'(1);
      ptr_next  = ptr;
    end else begin
      // window full: overwrite the oldest sample
      wr_addr   = ptr;
      fill_next = fill;
      ptr_next  = wrap_add(ptr, CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) mem[wr_addr] <= sample.rtt_sample;
    if (issue) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      window_size <= RST_WINDOW_SIZE;
      fill        <= '0;
      ptr         <= '0;
      cnt         <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cfg.we && cfg.idx == CFG_WINDOW_SIZE) begin
        window_size <= cfg.data[WSIZE_W-1:0];
        fill        <= '0;
        ptr         <= '0;
      end
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            fill  <= fill_next;
            ptr   <= ptr_next;
            full  <= (fill_next == size_eff);
            cnt   <= '0;
            rtt   <= sample.rtt_sample;
            lo    <= sample.rtt_sample;
            hi    <= sample.rtt_sample;
            state <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (issue) cnt <= cnt + CNT_W'(1);
          if (rd_vld) begin
            if (rd_data < lo) lo <= rd_data;
            if (rd_data > hi) hi <= rd_data;
          end
          if (!issue && !rd_vld) state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= MAX_WINDOW) else $error("fill count beyond store depth");
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == F_SCAN) else $error("read data outside scan");

endmodule

`default_nettype wire

@@ hdl/rwdp_queue.sv @@
// ----------------------------------------------------------------------------
// rwdp_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rwdp_queue import rwdp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      push_ready,
  output logic      pop_valid,
  output job_t      pop_job,
  input  wire logic pop
);

  job_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

@@ hdl/rwdp_back.sv @@
// ----------------------------------------------------------------------------
// rwdp_back
// tracks propagation delay and computes drop probability by serial division
// ----------------------------------------------------------------------------
`default_nettype none

module rwdp_back import rwdp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_wr_t cfg,
  input  wire logic    pop_valid,
  input  wire job_t    pop_job,
  output logic         pop,
  rwdp_result_if.source result
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_DONE = 4'b1000
  } bstate_t;

  bstate_t             state;
  logic [PROB_W-1:0]   rtt_scale;
  logic [PROB_W-1:0]   min_drop;
  logic [RTT_BITS-1:0] tracked;
  job_t                job;
  logic                lowered;
  logic [RTT_BITS-1:0] diff;
  logic [RTT_BITS-1:0] den;
  logic [RTT_BITS:0]   rem;
  logic [QUO_BITS-1:0] sh;
  logic [STEP_W-1:0]   steps;

  logic [PROD_W-1:0]   prod;
  logic [RTT_BITS:0]   trial;
  logic [PROB_W:0]     sum;

  assign pop   = (state == B_IDLE) && pop_valid && !result.valid;
  assign prod  = PROD_W'(rtt_scale) * PROD_W'(diff);
  assign trial = {rem[RTT_BITS-1:0], sh[QUO_BITS-1]};
  assign sum   = (PROB_W+1)'(min_drop) + (PROB_W+1)'(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      rtt_scale    <= RST_RTT_SCALE;
      min_drop     <= RST_MIN_DROP;
      tracked      <= RST_INIT_DELAY;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) result.valid <= 1'b0;
      if (cfg.we) begin
        unique case (cfg.idx)
          CFG_RTT_SCALE:   rtt_scale   <= cfg.data[PROB_W-1:0];
          CFG_MIN_DROP:    min_drop    <= cfg.data[PROB_W-1:0];
          CFG_INIT_DELAY:  tracked     <= cfg.data[RTT_BITS-1:0];
          default: ;
        endcase
      end
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            job  <= pop_job;
            diff <= pop_job.rtt - pop_job.lo;
            den  <= pop_job.hi - pop_job.lo;
            sh   <= '0;
            if (pop_job.lo < tracked) begin
              tracked <= pop_job.lo;
              lowered <= 1'b1;
            end else begin
              lowered <= 1'b0;
            end
            state <= (pop_job.full && pop_job.hi != pop_job.lo) ? B_MUL : B_DONE;
          end
        end
        B_MUL: begin
          // quotient fits in QUO_BITS, so the top part is below den already
          rem   <= {1'b0, prod[PROD_W-1:QUO_BITS]};
          sh    <= prod[QUO_BITS-1:0];
          steps <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          if (trial >= {1'b0, den}) begin
            rem <= trial - {1'b0, den};
            sh  <= {sh[QUO_BITS-2:0], 1'b1};
          end else begin
            rem <= trial;
            sh  <= {sh[QUO_BITS-2:0], 1'b0};
          end
          steps <= steps + STEP_W'(1);
          if (steps == STEP_W'(QUO_BITS - 1)) state <= B_DONE;
        end
        B_DONE: begin
          result.valid              <= 1'b1;
          result.rtt_min            <= job.lo;
          result.rtt_max            <= job.hi;
          result.prop_delay         <= tracked;
          result.prop_delay_lowered <= lowered;
          result.window_full        <= job.full;
          if (!job.full) begin
            result.drop_prob <= '0;
          end else if (sum[PROB_W]) begin
            result.drop_prob <= {PROB_W{1'b1}};
          end else begin
            result.drop_prob <= sum[PROB_W-1:0];
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> rem < {1'b0, den}) else $error("division remainder too large");
  a_lowered_delay: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.prop_delay_lowered |-> result.prop_delay == result.rtt_min)
    else $error("lowered delay differs from window min");

endmodule

`default_nettype wire

@@ hdl/rtt_window_drop_probability.sv @@
// ----------------------------------------------------------------------------
// rtt_window_drop_probability
// sliding window rtt min/max, propagation delay and drop probability
// ----------------------------------------------------------------------------
// the front reads the store once per window sample in its scan, then the item
// passes the queue to the back, which runs the 16-step divider for full windows
// the front takes no new sample until its scan and push are through, as the
// sample store has a single read port; the back also takes one item at a time
// reset: synchronous, empties the window and loads register defaults
`default_nettype none

module rtt_window_drop_probability import rwdp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rwdp_sample_if.sink                sample,
  rwdp_result_if.source              result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_wr_t cfg;
  logic    push;
  job_t    push_job;
  logic    push_ready;
  logic    pop_valid;
  job_t    pop_job;
  logic    pop;

  assign cfg = '{we: cfg_we, idx: cfg_index, data: cfg_data};

  rwdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample     (sample),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  rwdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop        (pop)
  );

  rwdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ tb/rwdp_checker.sv @@
// ----------------------------------------------------------------------------
// rwdp_checker
// watches the sample and result channels, predicts the window statistics and
// drop probability of each sample and compares every result with them
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rwdp_checker import rwdp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rwdp_sample_if.monitor             sample,
  rwdp_result_if.monitor             result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [RTT_BITS-1:0] rtt_min;
    logic [RTT_BITS-1:0] rtt_max;
    logic [RTT_BITS-1:0] prop_delay;
    logic                lowered;
    logic                full;
    logic [PROB_W-1:0]   prob;
  } window_stats_t;

  logic [PROB_W-1:0]   factor_q, floor_q;
  logic [WSIZE_W-1:0]  wsize_q;
  logic [RTT_BITS-1:0] store_q [MAX_WINDOW];
  int                  fill_q, oldest_q;
  logic [RTT_BITS-1:0] delay_q;
  window_stats_t       stats_fifo [$];

  function automatic int window_len();
    if (wsize_q == 0) return 1;
    if (wsize_q > MAX_WINDOW) return MAX_WINDOW;
    return int'(wsize_q);
  endfunction

  task automatic predict_window(input logic [RTT_BITS-1:0] rtt);
    window_stats_t       s;
    int                  len;
    logic [RTT_BITS-1:0] lo, hi, v;
    logic [63:0]         q, p;
    len = window_len();
    if (fill_q < len) begin
      store_q[(oldest_q + fill_q) % MAX_WINDOW] = rtt;
      fill_q++;
    end else begin
      store_q[oldest_q] = rtt;
      oldest_q = (oldest_q + 1) % MAX_WINDOW;
    end
    lo = rtt;
    hi = rtt;
    for (int i = 0; i < fill_q; i++) begin
      v = store_q[(oldest_q + i) % MAX_WINDOW];
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    s.lowered = lo < delay_q;
    if (s.lowered) delay_q = lo;
    s.rtt_min = lo;
    s.rtt_max = hi;
    s.prop_delay = delay_q;
    s.full = fill_q == len;
    s.prob = '0;
    if (s.full) begin
      if (hi == lo) begin
        s.prob = floor_q;
      end else begin
        q = (64'(factor_q) * 64'(rtt - lo)) / 64'(hi - lo);
        p = 64'(floor_q) + q;
        s.prob = (p > 64'hFFFF) ? 16'hFFFF : p[15:0];
      end
    end
    stats_fifo.insert(stats_fifo.size(), s);
  endtask

  always @(posedge clk) begin
    window_stats_t e;
    if (rst) begin
      factor_q = RST_RTT_SCALE;
      floor_q = RST_MIN_DROP;
      wsize_q = RST_WINDOW_SIZE;
      delay_q = RST_INIT_DELAY;
      fill_q = 0;
      oldest_q = 0;
      stats_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RTT_SCALE:   factor_q = cfg_data[PROB_W-1:0];
          CFG_MIN_DROP:    floor_q = cfg_data[PROB_W-1:0];
          CFG_WINDOW_SIZE: begin
            wsize_q = cfg_data[WSIZE_W-1:0];
            fill_q = 0;
            oldest_q = 0;
          end
          CFG_INIT_DELAY:  delay_q = cfg_data[RTT_BITS-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (stats_fifo.size() == 0) begin
          $error("result item with no sample waiting");
          fail_count++;
        end else begin
          e = stats_fifo[0];
          stats_fifo.delete(0);
          if (result.rtt_min !== e.rtt_min) begin
            $error("rtt_min expected %0d got %0d", e.rtt_min, result.rtt_min);
            fail_count++;
          end
          if (result.rtt_max !== e.rtt_max) begin
            $error("rtt_max expected %0d got %0d", e.rtt_max, result.rtt_max);
            fail_count++;
          end
          if (result.prop_delay !== e.prop_delay) begin
            $error("prop_delay expected %0d got %0d", e.prop_delay, result.prop_delay);
            fail_count++;
          end
          if (result.prop_delay_lowered !== e.lowered) begin
            $error("prop_delay_lowered expected %0d got %0d", e.lowered,
                   result.prop_delay_lowered);
            fail_count++;
          end
          if (result.window_full !== e.full) begin
            $error("window_full expected %0d got %0d", e.full, result.window_full);
            fail_count++;
          end
          if (result.drop_prob !== e.prob) begin
            $error("drop_prob expected %0d got %0d", e.prob, result.drop_prob);
            fail_count++;
          end
        end
      end
      if (sample.valid && sample.ready) predict_window(sample.rtt_sample);
    end
    pending = stats_fifo.size();
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives rtt samples and register settings into the window block under
// random idling and back pressure; the checker judges every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top import rwdp_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending;
  int                    src_idle_pct = 0, snk_idle_pct = 0;
  bit                    hold_off = 1'b0;
  int                    idle_cycles = 0;

  rwdp_sample_if sample ();
  rwdp_result_if result ();

  rtt_window_drop_probability uut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rwdp_checker u_checker (
    .clk(clk), .rst(rst), .sample(sample.monitor), .result(result.monitor),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    sample.valid = 1'b0;
    sample.rtt_sample = '0;
    result.ready = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst || hold_off) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // valid stays up between items sent back to back
  task automatic send_rtt(input logic [RTT_BITS-1:0] rtt);
    while ($urandom_range(99) < src_idle_pct) begin
      sample.valid <= 1'b0;
      @(negedge clk);
    end
    sample.valid <= 1'b1;
    sample.rtt_sample <= rtt;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [RTT_BITS-1:0] rand_rtt();
    case ($urandom_range(3))
      0: return RTT_BITS'($urandom_range(200));
      1: return RTT_BITS'($urandom);
      2: return 24'hFFFFFF - RTT_BITS'($urandom_range(200));
      default: return 24'd1000 + RTT_BITS'($urandom_range(3000));
    endcase
  endfunction

  initial begin
    logic [RTT_BITS-1:0] base;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes with default registers, then small windows and a clamped one
    send_rtt(24'hFFFFFF);
    send_rtt(24'd0);
    send_rtt(24'd0);
    send_rtt(24'h800000);
    wait_idle();
    write_reg(CFG_WINDOW_SIZE, 24'd1);
    write_reg(CFG_RTT_SCALE, 24'hFFFF);
    write_reg(CFG_MIN_DROP, 24'hFFFF);
    write_reg(CFG_INIT_DELAY, 24'd5);
    send_rtt(24'd7);
    send_rtt(24'd3);
    wait_idle();
    write_reg(CFG_WINDOW_SIZE, 24'd0);   // acts as one
    write_reg(CFG_MIN_DROP, 24'hFF00);   // no division in a one-sample window, so the result is this floor
    send_rtt(24'd9);
    wait_idle();
    write_reg(CFG_WINDOW_SIZE, 24'd3);
    write_reg(CFG_MIN_DROP, 24'h0);
    write_reg(CFG_INIT_DELAY, 24'hFFFFFF);
    send_rtt(24'd10);
    send_rtt(24'd20);
    send_rtt(24'd0);
    send_rtt(24'hFFFFFF);
    send_rtt(24'd15);
    wait_idle();
    write_reg(CFG_WINDOW_SIZE, 24'd127);  // clamps to the store depth
    write_reg(CFG_RTT_SCALE, 24'h0);
    for (int i = 0; i < 6; i++) send_rtt(rand_rtt());
    wait_idle();

    // random phases with rotating idling and settings
    for (int ph = 0; ph < 12; ph++) begin
      src_idle_pct = (ph < 4) ? 32 : (ph < 8) ? 76 : 0;
      snk_idle_pct = (ph < 4) ? 76 : (ph < 8) ? 32 : 0;
      write_reg(CFG_RTT_SCALE, (ph % 3 == 0) ? 24'hFFFF : 24'($urandom_range(65535)));
      write_reg(CFG_MIN_DROP, (ph % 4 == 1) ? 24'hFFFF : 24'($urandom_range(2000)));
      write_reg(CFG_WINDOW_SIZE, (ph == 5) ? 24'd64 : 24'($urandom_range(1, 12)));
      write_reg(CFG_INIT_DELAY, (ph % 2) ? 24'hFFFFFF : 24'($urandom));
      if (ph == 9) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      base = rand_rtt();
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(3) == 0) send_rtt(rand_rtt());
        else send_rtt(base + RTT_BITS'($urandom_range(500)));
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rwdp_pkg.sv
hdl/rwdp_if.sv
hdl/rwdp_front.sv
hdl/rwdp_queue.sv
hdl/rwdp_back.sv
hdl/rtt_window_drop_probability.sv
tb/rwdp_checker.sv
tb/tb_top.sv
